[hw/rtl/median7_stream_filter_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion helpers for the median filter block
// Shorthand macros for the clocked checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MEDIAN7_STREAM_FILTER_UNIT_ASSERT_SVH
`define MEDIAN7_STREAM_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSFU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("median filter check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("median filter check failed");

`endif

[hw/rtl/m7sf_pkg.sv]
// ----------------------------------------------------------------------------
// Median filter package
// Default sizes and the shared pipeline tag type.
// ----------------------------------------------------------------------------
package m7sf_pkg;

   // Default sample width and window radius (window is 2*radius+1 taps).
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int RADIUS_DEF       = 3;

   // Control that travels with one window position down the pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

[hw/rtl/median7_stream_filter_unit.sv]
// ----------------------------------------------------------------------------
// Seven-tap streaming median filter
// Median of a sliding window with the first and last samples of a sequence
// replicated past its ends.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on req_*: one signed sample in req_tdata, req_tlast marks
//    the last sample of a sequence. Results leave on rsp_*: one median per
//    sample position in rsp_tdata, rsp_tlast on the last median of a sequence.
//  - Results lag input by RADIUS positions. The first RADIUS requests of a
//    sequence give no result; each later request gives one.
//  - A result is registered in the window, then in the order stage, then in
//    the output register, from which it appears on rsp_tvalid.
//  - Throughput is one request per cycle while rsp_tready is high. The last
//    request of a sequence is followed by a flush in which the window shifts
//    in the last sample again and req_tready is low; the flush shifts emit
//    the remaining medians.
//  - When rsp_tready is low the output register holds its result, the
//    window and order stages fill up behind it, then req_tready drops.
//  - After reset the block waits for the first sample of a new sequence,
//    which fills the whole window.
// ----------------------------------------------------------------------------
module median7_stream_filter_unit
   import m7sf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int RADIUS       = RADIUS_DEF,
   localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [SAMPLE_WIDTH-1:0] sample, rest zero
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [SAMPLE_WIDTH-1:0] median, rest zero
   output logic              rsp_tlast
);

   localparam int N      = 2 * RADIUS + 1;
   localparam int SEEN_W = $clog2(RADIUS + 1);
   localparam int STEP_W = $clog2(2 * RADIUS + 1);

   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic signed [SAMPLE_WIDTH-1:0] newest_prev;
   logic signed [SAMPLE_WIDTH-1:0] tap [N];
   logic signed [SAMPLE_WIDTH-1:0] med;
   logic [SEEN_W-1:0]              seen_ff, seen_in;
   logic [SEEN_W-1:0]              base_ff, base_in;
   logic [STEP_W-1:0]              step_ff, step_in;
   logic                           flush_ff, flush_in;
   tag_type                        w_tag_ff, w_tag_in;
   logic                           win_ready;
   logic                           adv1;
   logic                           accept;
   logic                           flush_shift;
   logic                           shift;
   logic                           fill;
   logic                           emit;
   logic                           flush_done;

   assign sample = $signed(req_tdata[SAMPLE_WIDTH-1:0]);

   // Handshake and window shift control.
   assign adv1        = !w_tag_ff.valid || win_ready;
   assign req_tready  = adv1 && !flush_ff;
   assign accept      = req_tvalid && req_tready;
   assign flush_shift = adv1 && flush_ff;
   assign shift       = accept || flush_shift;
   assign fill        = accept && (seen_ff == '0);
   assign flush_done  = flush_ff && (step_ff == STEP_W'(RADIUS));
   assign newest_prev = accept ? sample : tap[N-1];

   // A shift yields a median once its centre is a real sample position.
   always_comb begin
      if (flush_ff) begin
         emit = (STEP_W'(base_ff) + step_ff) >= STEP_W'(RADIUS);
      end else begin
         emit = (seen_ff == SEEN_W'(RADIUS));
      end
   end

   // Window tag: set on a shift, cleared when the rank stage takes it.
   always_comb begin
      w_tag_in = w_tag_ff;
      if (shift) begin
         w_tag_in.valid = emit;
         w_tag_in.last  = flush_shift && flush_done;
      end else if (win_ready) begin
         w_tag_in.valid = 1'b0;
      end
   end

   // Sequence bookkeeping: samples seen, then the flush after the last one.
   always_comb begin
      seen_in  = seen_ff;
      base_in  = base_ff;
      step_in  = step_ff;
      flush_in = flush_ff;
      if (accept) begin
         if (req_tlast) begin
            seen_in  = '0;
            base_in  = seen_ff;
            step_in  = STEP_W'(1);
            flush_in = 1'b1;
         end else if (seen_ff != SEEN_W'(RADIUS)) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
      end else if (flush_shift) begin
         if (flush_done) begin
            flush_in = 1'b0;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         flush_ff <= 1'b0;
         step_ff  <= '0;
         base_ff  <= '0;
         w_tag_ff <= '0;
      end else begin
         seen_ff  <= seen_in;
         flush_ff <= flush_in;
         step_ff  <= step_in;
         base_ff  <= base_in;
         w_tag_ff <= w_tag_in;
      end
   end

   // Row of window cells, oldest at index 0; the newest takes the request.
   for (genvar k = 0; k < N; k++) begin : g_cell
      if (k == N - 1) begin : g_newest
         m7sf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
         ) u_cell (
            .clock     (clock),
            .fill      (fill),
            .shift     (shift),
            .fill_data (sample),
            .prev_data (newest_prev),
            .tap       (tap[k])
         );
      end else begin : g_inner
         m7sf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
         ) u_cell (
            .clock     (clock),
            .fill      (fill),
            .shift     (shift),
            .fill_data (sample),
            .prev_data (tap[k+1]),
            .tap       (tap[k])
         );
      end
   end

   // Rank selection and output register.
   m7sf_rank #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .RADIUS       (RADIUS)
   ) u_rank (
      .clock      (clock),
      .reset      (reset),
      .win_tag    (w_tag_ff),
      .win_ready  (win_ready),
      .win        (tap),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_median (med),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = DATA_W'($unsigned(med));

   // Checks on the sequence control and the window stage.
`include "median7_stream_filter_unit_assert.svh"

   `MSFU_ASSERT_NEXT(a_flush_starts, clock, reset, accept && req_tlast, flush_ff && !req_tready)
   `MSFU_ASSERT_NEXT(a_flush_ends, clock, reset, flush_shift && flush_done, !flush_ff && seen_ff == '0)
   `MSFU_ASSERT_NEXT(a_window_held, clock, reset, w_tag_ff.valid && !win_ready, w_tag_ff.valid)
   `MSFU_ASSERT_SAME(a_flush_last, clock, reset, shift && w_tag_in.last, w_tag_in.valid && flush_ff)

endmodule

[hw/rtl/m7sf_cell.sv]
// ----------------------------------------------------------------------------
// Median filter window cell
// One tap of the sample window: loads the fill value at the start of a
// sequence, otherwise takes its neighbor's sample on every shift.
// ----------------------------------------------------------------------------
module m7sf_cell
   import m7sf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           fill,
   input  logic                           shift,
   input  logic signed [SAMPLE_WIDTH-1:0] fill_data,
   input  logic signed [SAMPLE_WIDTH-1:0] prev_data,
   output logic signed [SAMPLE_WIDTH-1:0] tap
);

   logic signed [SAMPLE_WIDTH-1:0] q_ff;
   logic signed [SAMPLE_WIDTH-1:0] q_in;

   // Fill wins over shift; otherwise the tap holds.
   always_comb begin
      q_in = q_ff;
      if (fill) begin
         q_in = fill_data;
      end else if (shift) begin
         q_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign tap = q_ff;

endmodule

[hw/rtl/m7sf_rank.sv]
// ----------------------------------------------------------------------------
// Median filter rank selector
// Two-stage pipeline: registers the pairwise order matrix of a window, then
// picks the tap whose rank is the middle one and holds it in the output
// register.
// ----------------------------------------------------------------------------
module m7sf_rank
   import m7sf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int RADIUS       = RADIUS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tag_type                        win_tag,
   output logic                           win_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] win [2*RADIUS+1],
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [SAMPLE_WIDTH-1:0] out_median,
   output logic                           out_last
);

   localparam int N      = 2 * RADIUS + 1;
   localparam int RANK_W = $clog2(N);

   logic signed [SAMPLE_WIDTH-1:0] vals_ff [N];
   logic [N-1:0]                   below_ff [N];
   logic [N-1:0]                   below_in [N];
   tag_type                        s2_ff;
   logic                           adv2;
   logic                           adv3;
   logic [RANK_W-1:0]              rank [N];
   logic signed [SAMPLE_WIDTH-1:0] med_in;
   logic                           out_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] med_ff;
   logic                           last_ff;

   // Stage advance: each stage moves when the one after it is free.
   assign adv3      = !out_valid_ff || out_ready;
   assign adv2      = !s2_ff.valid || adv3;
   assign win_ready = adv2;

   // Tap j ranks below tap i when smaller, ties broken by tap position.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            below_in[i][j] = (i != j) &&
               ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)));
         end
      end
   end

   // Order matrix stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else if (adv2) begin
         s2_ff <= win_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         vals_ff  <= win;
         below_ff <= below_in;
      end
   end

   // Exactly one tap has the middle rank; select it with an and-or mux.
   always_comb begin
      med_in = '0;
      for (int i = 0; i < N; i++) begin
         rank[i] = RANK_W'($countones(below_ff[i]));
         if (rank[i] == RANK_W'(RADIUS)) begin
            med_in = med_in | vals_ff[i];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv3) begin
         out_valid_ff <= s2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         med_ff  <= med_in;
         last_ff <= s2_ff.last;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_median = med_ff;
   assign out_last   = last_ff;

endmodule
